// ===== design/midpoint_ellipse_points_defines.svh =====
// Assertion macros for the ellipse point generator.
// Each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH
`define MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MEP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("midpoint ellipse: same-cycle check failed");

// next-cycle implication
`define MEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("midpoint ellipse: next-cycle check failed");

`else

`define MEP_ASSERT_IMP(label, ante, cons)
`define MEP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/mep_pkg.sv =====
package mep_pkg;

    localparam int AXIS_BITS_DEF  = 10;
    localparam int COORD_BITS_DEF = 12;
    localparam int OUT_W          = 14;

    localparam logic KIND_START = 1'b0;

    typedef logic [1:0] t_region;
    localparam t_region REG_START = 2'd0;
    localparam t_region REG_ONE   = 2'd1;
    localparam t_region REG_TWO   = 2'd2;

    // multiplier operand selection
    typedef logic [3:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE    = 4'd0;
    localparam t_mul_sel MUL_AA      = 4'd1;
    localparam t_mul_sel MUL_BB      = 4'd2;
    localparam t_mul_sel MUL_ASQ_B   = 4'd3;
    localparam t_mul_sel MUL_TX_TX   = 4'd4;
    localparam t_mul_sel MUL_BSQ_P   = 4'd5;
    localparam t_mul_sel MUL_YM_YM   = 4'd6;
    localparam t_mul_sel MUL_ASQ_P   = 4'd7;
    localparam t_mul_sel MUL_ASQ_BSQ = 4'd8;

    // decision register update
    typedef logic [2:0] t_dec_op;
    localparam t_dec_op DEC_HOLD  = 3'd0;
    localparam t_dec_op DEC_INIT  = 3'd1;
    localparam t_dec_op DEC_STEP1 = 3'd2;
    localparam t_dec_op DEC_STEP2 = 3'd3;
    localparam t_dec_op DEC_LOADP = 3'd4;
    localparam t_dec_op DEC_ADD4P = 3'd5;
    localparam t_dec_op DEC_SUB4P = 3'd6;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     asq_ld;
        logic     bsq_ld;
        logic     sy_ld;
        logic     step1;
        logic     step2;
        t_dec_op  dec_op;
        logic     out_ld;
        t_region  out_region;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic slope_lt;
        logic offy_zero;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/mep_datapath.sv =====
module mep_datapath import mep_pkg::*; #(
    parameter int AXIS_BITS  = AXIS_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [AXIS_BITS-1:0]  i_semi_axis_x,
    input  logic [AXIS_BITS-1:0]  i_semi_axis_y,
    input  logic [COORD_BITS-1:0] i_centre_x,
    input  logic [COORD_BITS-1:0] i_centre_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_W-1:0]      o_right_x,
    output logic [OUT_W-1:0]      o_left_x,
    output logic [OUT_W-1:0]      o_upper_y,
    output logic [OUT_W-1:0]      o_lower_y,
    output t_region               o_region,
    output logic                  o_last
);

    localparam int OFF_W   = AXIS_BITS + 1;
    localparam int SQ_W    = 2 * AXIS_BITS;
    localparam int SLOPE_W = 3 * AXIS_BITS + 3;
    localparam int DEC_W   = (4 * AXIS_BITS + 8 > 64) ? 64 : 4 * AXIS_BITS + 8;
    localparam int MA_W    = 2 * AXIS_BITS;
    localparam int MB_W    = 2 * AXIS_BITS + 4;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int CALC_W  = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + OUT_W;

    logic [OFF_W-1:0]      r_off_x, r_off_y, n_off_x, n_off_y;
    logic [SLOPE_W-1:0]    r_sx, r_sy, n_sx, n_sy;
    logic [DEC_W-1:0]      r_dec, n_dec;
    logic [SQ_W-1:0]       r_asq, r_bsq;
    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_stepped, n_stepped;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_right_x, r_left_x, r_upper_y, r_lower_y;
    t_region               r_region;
    logic                  r_last;

    logic [MA_W-1:0]    op_a;
    logic [MB_W-1:0]    op_b;
    logic [PROD_W-1:0]  mul_res;
    logic [OFF_W:0]     tx;
    logic [OFF_W-1:0]   ym;
    logic [SLOPE_W-1:0] asq2, bsq2;
    logic [DEC_W-1:0]   p_dec, sx_dec, sy_dec, asq_dec, bsq_dec;
    logic               dec_neg, dec_zero;

    assign tx       = {r_off_x, 1'b1};
    assign ym       = r_off_y - OFF_W'(1);
    assign asq2     = SLOPE_W'(r_asq) << 1;
    assign bsq2     = SLOPE_W'(r_bsq) << 1;
    assign p_dec    = DEC_W'(r_prod);
    assign sx_dec   = DEC_W'(r_sx);
    assign sy_dec   = DEC_W'(r_sy);
    assign asq_dec  = DEC_W'(r_asq);
    assign bsq_dec  = DEC_W'(r_bsq);
    assign dec_neg  = r_dec[DEC_W-1];
    assign dec_zero = (r_dec == '0);

    // shared multiplier, one product per cycle
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.mul_sel)
            MUL_NONE: begin
                op_a = '0;
                op_b = '0;
            end
            MUL_AA: begin
                op_a = MA_W'(i_semi_axis_x);
                op_b = MB_W'(i_semi_axis_x);
            end
            MUL_BB: begin
                op_a = MA_W'(r_off_y);
                op_b = MB_W'(r_off_y);
            end
            MUL_ASQ_B: begin
                op_a = r_asq;
                op_b = MB_W'(r_off_y);
            end
            MUL_TX_TX: begin
                op_a = MA_W'(tx);
                op_b = MB_W'(tx);
            end
            MUL_BSQ_P: begin
                op_a = r_bsq;
                op_b = MB_W'(r_prod);
            end
            MUL_YM_YM: begin
                op_a = MA_W'(ym);
                op_b = MB_W'(ym);
            end
            MUL_ASQ_P: begin
                op_a = r_asq;
                op_b = MB_W'(r_prod);
            end
            MUL_ASQ_BSQ: begin
                op_a = r_asq;
                op_b = MB_W'(r_bsq);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_res = op_a * op_b;

    // offsets and slope terms
    always_comb begin
        n_off_x   = r_off_x;
        n_off_y   = r_off_y;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_stepped = r_stepped;
        priority if (i_cmd.load) begin
            n_off_x = '0;
            n_off_y = OFF_W'(i_semi_axis_y);
            n_sx    = '0;
        end else if (i_cmd.sy_ld) begin
            n_sy = SLOPE_W'(r_prod) << 1;
        end else if (i_cmd.step1) begin
            n_off_x   = r_off_x + OFF_W'(1);
            n_sx      = r_sx + bsq2;
            n_stepped = !dec_neg;
            if (!dec_neg) begin
                n_off_y = r_off_y - OFF_W'(1);
                n_sy    = r_sy - asq2;
            end
        end else if (i_cmd.step2) begin
            n_off_y   = r_off_y - OFF_W'(1);
            n_sy      = r_sy - asq2;
            n_stepped = dec_neg || dec_zero;
            if (dec_neg || dec_zero) begin
                n_off_x = r_off_x + OFF_W'(1);
                n_sx    = r_sx + bsq2;
            end
        end else begin
            n_stepped = r_stepped;
        end
    end

    // decision value, kept scaled by four
    always_comb begin
        n_dec = r_dec;
        unique case (i_cmd.dec_op)
            DEC_HOLD:  n_dec = r_dec;
            DEC_INIT:  n_dec = (bsq_dec << 2) + asq_dec - (p_dec << 2);
            DEC_STEP1: n_dec = r_dec + (bsq_dec << 2) + (sx_dec << 2)
                             - (r_stepped ? (sy_dec << 2) : '0);
            DEC_STEP2: n_dec = r_dec + (asq_dec << 2) - (sy_dec << 2)
                             + (r_stepped ? (sx_dec << 2) : '0);
            DEC_LOADP: n_dec = p_dec;
            DEC_ADD4P: n_dec = r_dec + (p_dec << 2);
            DEC_SUB4P: n_dec = r_dec - (p_dec << 2);
            default:   n_dec = r_dec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_off_x   <= n_off_x;
        r_off_y   <= n_off_y;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_dec     <= n_dec;
        r_stepped <= n_stepped;
        r_prod    <= mul_res;
        if (i_cmd.load) begin
            r_cx <= i_centre_x;
            r_cy <= i_centre_y;
        end
        if (i_cmd.asq_ld) begin
            r_asq <= SQ_W'(r_prod);
        end
        if (i_cmd.bsq_ld) begin
            r_bsq <= SQ_W'(r_prod);
        end
        if (i_cmd.out_ld) begin
            r_right_x <= OUT_W'(CALC_W'(r_cx) + CALC_W'(r_off_x));
            r_left_x  <= OUT_W'(CALC_W'(r_cx) - CALC_W'(r_off_x));
            r_upper_y <= OUT_W'(CALC_W'(r_cy) - CALC_W'(r_off_y));
            r_lower_y <= OUT_W'(CALC_W'(r_cy) + CALC_W'(r_off_y));
            r_region  <= i_cmd.out_region;
            r_last    <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.slope_lt  = (r_sx < r_sy);
    assign o_stat.offy_zero = (r_off_y == '0);
    assign o_stat.out_free  = !r_out_valid || i_ready;

    assign o_valid   = r_out_valid;
    assign o_right_x = r_right_x;
    assign o_left_x  = r_left_x;
    assign o_upper_y = r_upper_y;
    assign o_lower_y = r_lower_y;
    assign o_region  = r_region;
    assign o_last    = r_last;

endmodule

// ===== design/mep_ctrl.sv =====
module mep_ctrl import mep_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_kind,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT_B = 4'd1;
    localparam logic [3:0] ST_INIT_C = 4'd2;
    localparam logic [3:0] ST_INIT_D = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_STEP_B = 4'd5;
    localparam logic [3:0] ST_R2_1   = 4'd6;
    localparam logic [3:0] ST_R2_2   = 4'd7;
    localparam logic [3:0] ST_R2_3   = 4'd8;
    localparam logic [3:0] ST_R2_4   = 4'd9;
    localparam logic [3:0] ST_R2_5   = 4'd10;
    localparam logic [3:0] ST_R2_6   = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    t_region    r_region, n_region;
    logic       emit;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_region = r_region;
        emit     = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.dec_op  = DEC_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_kind == KIND_START) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.mul_sel = MUL_AA;
                        n_region      = REG_START;
                        n_state       = ST_INIT_B;
                    end else if (r_phase == PH_ONE) begin
                        o_cmd.step1 = 1'b1;
                        n_region    = REG_ONE;
                        n_state     = ST_STEP_B;
                    end else if (r_phase == PH_TWO) begin
                        o_cmd.step2 = 1'b1;
                        n_region    = REG_TWO;
                        n_state     = ST_STEP_B;
                    end else begin
                        // step with nothing running: drop it
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_INIT_B: begin
                o_cmd.asq_ld  = 1'b1;
                o_cmd.mul_sel = MUL_BB;
                n_state       = ST_INIT_C;
            end
            ST_INIT_C: begin
                o_cmd.bsq_ld  = 1'b1;
                o_cmd.mul_sel = MUL_ASQ_B;
                n_state       = ST_INIT_D;
            end
            ST_INIT_D: begin
                o_cmd.sy_ld  = 1'b1;
                o_cmd.dec_op = DEC_INIT;
                n_phase      = PH_ONE;
                n_state      = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_stat.slope_lt) begin
                    emit = 1'b1;
                end else if (i_stat.offy_zero) begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                end else begin
                    n_phase = PH_TWO;
                    n_state = ST_R2_1;
                end
            end
            ST_STEP_B: begin
                if (r_phase == PH_ONE) begin
                    o_cmd.dec_op = DEC_STEP1;
                    priority if (i_stat.slope_lt) begin
                        emit = 1'b1;
                    end else if (i_stat.offy_zero) begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                    end else begin
                        n_phase = PH_TWO;
                        n_state = ST_R2_1;
                    end
                end else begin
                    o_cmd.dec_op = DEC_STEP2;
                    if (i_stat.offy_zero) begin
                        n_phase = PH_IDLE;
                    end
                    emit = 1'b1;
                end
            end
            // region-two start value, products taken one after another
            ST_R2_1: begin
                o_cmd.mul_sel = MUL_TX_TX;
                n_state       = ST_R2_2;
            end
            ST_R2_2: begin
                o_cmd.mul_sel = MUL_BSQ_P;
                n_state       = ST_R2_3;
            end
            ST_R2_3: begin
                o_cmd.dec_op  = DEC_LOADP;
                o_cmd.mul_sel = MUL_YM_YM;
                n_state       = ST_R2_4;
            end
            ST_R2_4: begin
                o_cmd.mul_sel = MUL_ASQ_P;
                n_state       = ST_R2_5;
            end
            ST_R2_5: begin
                o_cmd.dec_op  = DEC_ADD4P;
                o_cmd.mul_sel = MUL_ASQ_BSQ;
                n_state       = ST_R2_6;
            end
            ST_R2_6: begin
                o_cmd.dec_op = DEC_SUB4P;
                emit         = 1'b1;
            end
            ST_EMIT: begin
                emit = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the point to the output register, or hold until it drains
        if (emit) begin
            if (i_stat.out_free) begin
                o_cmd.out_ld = 1'b1;
                n_state      = ST_IDLE;
            end else begin
                n_state = ST_EMIT;
            end
        end
        o_cmd.out_region = r_region;
        o_cmd.out_last   = (n_phase == PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_IDLE;
            r_region <= REG_START;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_region <= n_region;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== design/midpoint_ellipse_points.sv =====
// Midpoint ellipse point generator.
// Slave stream: a request with tuser = 0 starts an ellipse from the semi-axes
// and centre in tdata; tuser = 1 advances the running ellipse by one point.
// Master stream: one point set per request (none for a step with no ellipse
// running): four coordinates in tdata, the region (0 start, 1, 2) in tuser,
// and tlast on the final point of the ellipse.
// A step passes through the step state to the output register; a start
// passes through the set-up states and the check state, and either one
// entering region two goes on through the region-two states, for five
// products through the single shared multiplier. A new request is taken
// only in the idle state, once the current one is handed over.
// Each step is a handful of additions; the multiplier runs only at start and
// at the change to region two.
// The result waits in an output register, and the next request is taken
// while it waits; a stalled receiver holds the block only once a second
// result is ready.
// Reset (synchronous, active low) drops any running ellipse and any result
// not yet taken.
`include "midpoint_ellipse_points_defines.svh"

module midpoint_ellipse_points import mep_pkg::*; #(
    parameter int AXIS_BITS  = AXIS_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_DATA_W = ((2 * AXIS_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // semi_axis_x, semi_axis_y, centre_x, centre_y, zero fill
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // right_x, left_x, upper_y, lower_y
    output logic [4*OUT_W-1:0]   m_axis_tdata,
    // region
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int AX_LO = 0;
    localparam int AY_LO = AXIS_BITS;
    localparam int CX_LO = 2 * AXIS_BITS;
    localparam int CY_LO = 2 * AXIS_BITS + COORD_BITS;

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [OUT_W-1:0] right_x, left_x, upper_y, lower_y;
    t_region          region;

    mep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mep_datapath #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_semi_axis_x (s_axis_tdata[AX_LO +: AXIS_BITS]),
        .i_semi_axis_y (s_axis_tdata[AY_LO +: AXIS_BITS]),
        .i_centre_x    (s_axis_tdata[CX_LO +: COORD_BITS]),
        .i_centre_y    (s_axis_tdata[CY_LO +: COORD_BITS]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_right_x     (right_x),
        .o_left_x      (left_x),
        .o_upper_y     (upper_y),
        .o_lower_y     (lower_y),
        .o_region      (region),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {lower_y, upper_y, left_x, right_x};
    assign m_axis_tuser = region;

    // the final point of an ellipse always sits on the horizontal axis
    `MEP_ASSERT_IMP(a_last_on_axis, m_axis_tvalid && m_axis_tlast, upper_y == lower_y)
    `MEP_ASSERT_IMP(a_load_slot_free, dp_cmd.out_ld, dp_stat.out_free)
    `MEP_ASSERT_IMP(a_idle_no_load, s_axis_tready, !dp_cmd.out_ld)
    `MEP_ASSERT_NEXT(a_load_shows, dp_cmd.out_ld, m_axis_tvalid)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mep_pkg::*;

    localparam int IN_W = 48;
    localparam logic KIND_STEP = ~KIND_START;
    localparam int DRAW_TARGET = 800;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_POINT, CHK_NONE} row_check_e;
    typedef enum logic [1:0] {PH_IDLE, PH_ONE, PH_TWO} ellipse_phase_e;

    typedef struct packed {
        logic signed [13:0] right_x;
        logic signed [13:0] left_x;
        logic signed [13:0] upper_y;
        logic signed [13:0] lower_y;
        t_region            region;
        logic               last;
    } point_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  ax;
        logic [9:0]  ay;
        logic [11:0] cx;
        logic [11:0] cy;
        row_check_e  chk;
        point_t      want;
    } row_t;

    localparam point_t NO_PT = '0;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic            s_axis_tuser;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [55:0]     m_axis_tdata;
    logic [1:0]      m_axis_tuser;
    logic            m_axis_tlast;

    midpoint_ellipse_points u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predicted ellipse state, kept at 64 bits, wider than the block's decision register
    logic [63:0]    off_x, off_y, slope_x, slope_y, dec, asq, bsq, ctr_x, ctr_y;
    ellipse_phase_e phase;

    point_t expected_points[$];
    int     points_drawn;
    int     mismatches;
    int     stall_count;
    bit     quiet;

    row_t directed_rows[] = '{
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_NONE,  NO_PT},
        '{KIND_START, 10'd0,    10'd0,    12'd0,    12'd0,    CHK_POINT,
          '{14'sd0, 14'sd0, 14'sd0, 14'sd0, REG_START, 1'b1}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_NONE,  NO_PT},
        '{KIND_START, 10'd1023, 10'd1023, 12'd4095, 12'd4095, CHK_POINT,
          '{14'sd4095, 14'sd4095, 14'sd3072, 14'sd5118, REG_START, 1'b0}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        // new start drops the running ellipse; flat one ends at once
        '{KIND_START, 10'd5,    10'd0,    12'd100,  12'd200,  CHK_POINT,
          '{14'sd100, 14'sd100, 14'sd200, 14'sd200, REG_START, 1'b1}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_NONE,  NO_PT},
        // zero horizontal axis: straight into region two
        '{KIND_START, 10'd0,    10'd3,    12'd10,   12'd4095, CHK_POINT,
          '{14'sd10, 14'sd10, 14'sd4092, 14'sd4098, REG_START, 1'b0}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_NONE,  NO_PT},
        // region one runs down to y zero, region two never entered
        '{KIND_START, 10'd4,    10'd1,    12'd0,    12'd0,    CHK_POINT,
          '{14'sd0, 14'sd0, -14'sd1, 14'sd1, REG_START, 1'b0}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_NONE,  NO_PT},
        '{KIND_START, 10'd2,    10'd2,    12'd2047, 12'd2048, CHK_POINT,
          '{14'sd2047, 14'sd2047, 14'sd2046, 14'sd2050, REG_START, 1'b0}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT},
        '{KIND_START, 10'd1023, 10'd1023, 12'd0,    12'd0,    CHK_POINT,
          '{14'sd0, 14'sd0, -14'sd1023, 14'sd1023, REG_START, 1'b0}},
        '{KIND_STEP,  10'd0,    10'd0,    12'd0,    12'd0,    CHK_PREDICT, NO_PT}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic void begin_region_two();
        logic [63:0] tx, ym;
        tx = 64'd2 * off_x + 64'd1;
        ym = (off_y == 0) ? 64'd1 : off_y - 64'd1;
        dec = bsq * tx * tx + 64'd4 * asq * ym * ym - 64'd4 * asq * bsq;
        phase = (off_y != 0) ? PH_TWO : PH_IDLE;
    endfunction

    function automatic bit advance_ellipse(input logic kind, input logic [9:0] ax,
                                           input logic [9:0] ay, input logic [11:0] cx,
                                           input logic [11:0] cy, output point_t pt);
        t_region rg;
        rg = REG_START;
        pt = NO_PT;
        if (kind == KIND_START) begin
            ctr_x   = 64'(cx);
            ctr_y   = 64'(cy);
            asq     = 64'(ax) * 64'(ax);
            bsq     = 64'(ay) * 64'(ay);
            off_x   = 64'd0;
            off_y   = 64'(ay);
            slope_x = 64'd0;
            slope_y = 64'd2 * asq * 64'(ay);
            dec     = 64'd4 * bsq - 64'd4 * asq * 64'(ay) + asq;
            phase   = PH_ONE;
            if (!(slope_x < slope_y)) begin_region_two();
        end else if (phase == PH_ONE) begin
            rg = REG_ONE;
            off_x   = off_x + 64'd1;
            slope_x = slope_x + 64'd2 * bsq;
            if (dec[63]) begin
                dec = dec + 64'd4 * (bsq + slope_x);
            end else begin
                off_y   = off_y - 64'd1;
                slope_y = slope_y - 64'd2 * asq;
                dec     = dec + 64'd4 * (bsq + slope_x) - 64'd4 * slope_y;
            end
            if (!(slope_x < slope_y)) begin_region_two();
        end else if (phase == PH_TWO) begin
            rg = REG_TWO;
            off_y   = off_y - 64'd1;
            slope_y = slope_y - 64'd2 * asq;
            if (!dec[63] && dec != 0) begin
                dec = dec + 64'd4 * (asq - slope_y);
            end else begin
                off_x   = off_x + 64'd1;
                slope_x = slope_x + 64'd2 * bsq;
                dec     = dec + 64'd4 * (asq - slope_y + slope_x);
            end
            if (off_y == 0) phase = PH_IDLE;
        end else begin
            return 1'b0;
        end
        pt.right_x = 14'(ctr_x + off_x);
        pt.left_x  = 14'(ctr_x - off_x);
        pt.upper_y = 14'(ctr_y - off_y);
        pt.lower_y = 14'(ctr_y + off_y);
        pt.region  = rg;
        pt.last    = (phase == PH_IDLE);
        return 1'b1;
    endfunction

    // hold the request until taken; tvalid stays high for a back-to-back request
    task automatic send_request(input logic kind, input logic [9:0] ax, input logic [9:0] ay,
                                input logic [11:0] cx, input logic [11:0] cy,
                                input row_check_e chk, input point_t want);
        int     gap;
        bit     drew;
        point_t pred;
        gap = pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, cy, cx, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        drew = advance_ellipse(kind, ax, ay, cx, cy, pred);
        if (drew) points_drawn++;
        case (chk)
            CHK_POINT: expected_points.push_back(want);
            CHK_NONE: ;
            default: if (drew) expected_points.push_back(pred);
        endcase
    endtask

    initial begin
        int          pick;
        int          steps;
        bit          long_run;
        logic [9:0]  ax, ay;
        logic [11:0] cx, cy;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_START;
        s_axis_tdata  = '0;
        points_drawn  = 0;
        mismatches    = 0;
        off_x = '0; off_y = '0; slope_x = '0; slope_y = '0; dec = '0;
        asq = '0; bsq = '0; ctr_x = '0; ctr_y = '0;
        phase = PH_IDLE;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].ax, directed_rows[i].ay,
                         directed_rows[i].cx, directed_rows[i].cy,
                         directed_rows[i].chk, directed_rows[i].want);

        while (points_drawn < DRAW_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // noise: any kind, any fields
                send_request(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095)), CHK_PREDICT, NO_PT);
            end else begin
                // large ellipses are cut short by the next start; small ones run out
                long_run = (pick <= 2);
                ax = long_run ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 20));
                ay = long_run ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 20));
                cx = 12'($urandom_range(0, 4095));
                cy = 12'($urandom_range(0, 4095));
                send_request(KIND_START, ax, ay, cx, cy, CHK_PREDICT, NO_PT);
                steps = long_run ? $urandom_range(0, 30) : 4096;
                while (steps > 0 && phase != PH_IDLE) begin
                    send_request(KIND_STEP, 10'($urandom_range(0, 1023)),
                                 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                                 12'($urandom_range(0, 4095)), CHK_PREDICT, NO_PT);
                    steps--;
                end
                if ($urandom_range(0, 3) == 0)
                    send_request(KIND_STEP, 10'd0, 10'd0, 12'd0, 12'd0, CHK_PREDICT, NO_PT);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // alternate calm stretches with bursts of gaps on both sides
    initial begin
        quiet = 1'b0;
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge i_clk);
            quiet = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        point_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.right_x = m_axis_tdata[13:0];
            got.left_x  = m_axis_tdata[27:14];
            got.upper_y = m_axis_tdata[41:28];
            got.lower_y = m_axis_tdata[55:42];
            got.region  = m_axis_tuser;
            got.last    = m_axis_tlast;
            if (expected_points.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected point: got x %0d/%0d y %0d/%0d region %0d last %0d",
                         $time, got.right_x, got.left_x, got.upper_y, got.lower_y,
                         got.region, got.last);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: point mismatch: expected x %0d/%0d y %0d/%0d ",
                             $time, want.right_x, want.left_x, want.upper_y,
                             want.lower_y,
                             "region %0d last %0d, got x %0d/%0d y %0d/%0d ",
                             want.region, want.last, got.right_x, got.left_x,
                             got.upper_y, got.lower_y,
                             "region %0d last %0d", got.region, got.last);
                end
            end
        end
    end

    // watchdog: end the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial stall_count = 0;

endmodule
